FILE: design/dropblock_mask_apply_assert.svh
// Assertion macros used by dropblock_mask_apply.
`ifndef DROPBLOCK_MASK_APPLY_ASSERT_SVH
`define DROPBLOCK_MASK_APPLY_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define DBM_ASSERT_SAME(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// Condition implies consequence in the next cycle.
`define DBM_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/dbm_pkg.sv
// ----------------------------------------------------------------------------
// dbm_pkg
// Types and codes shared by the mask block, its checker and its testbench.
// ----------------------------------------------------------------------------
package dbm_pkg;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_SEED  = 2'd1,
		KIND_DATA  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		REG_PLANE_WIDTH = 3'd0,
		REG_BLOCK_WIDTH = 3'd1,
		REG_PLANE_COUNT = 3'd2,
		REG_THRESHOLD   = 3'd3,
		REG_TRAIN_MODE  = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_SDIV1,
		S_SDIV2,
		S_SBASE,
		S_SCELL,
		S_SDRAIN,
		S_DREAD,
		S_DCHK,
		S_DMUL,
		S_DDIV,
		S_DSAT,
		S_WOUT
	} state_t;

	localparam int CFG_WIDTH = 16;

endpackage

FILE: design/dbm_if.sv
// ----------------------------------------------------------------------------
// dbm_in_if / dbm_out_if
// Valid-ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface dbm_in_if #(parameter int DATA_WIDTH = 16);
	logic                         valid;
	logic                         ready;
	logic [1:0]                   kind;
	logic [15:0]                  random_fraction;
	logic signed [DATA_WIDTH-1:0] data_value;

	modport source (output valid, kind, random_fraction, data_value, input ready);
	modport sink (input valid, kind, random_fraction, data_value, output ready);
endinterface

interface dbm_out_if #(parameter int DATA_WIDTH = 16);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] scaled_value;
	logic                         mask_kept;
	logic                         no_kept_error;

	modport source (output valid, scaled_value, mask_kept, no_kept_error, input ready);
	modport sink (input valid, scaled_value, mask_kept, no_kept_error, output ready);
endinterface

FILE: design/dropblock_mask_apply.sv
// Start: a clearing pass over the whole mask memory runs before the next item is taken.
// Seed: stays idle if not dropped, else divides twice and marks a block_width^2 square.
// Data: straight to output with training off, else read, check and scale (serial divider).
// One item at a time; the result register frees the input while a beat waits.
// Reset: async active low; a clearing pass over the whole mask memory follows.
// ----------------------------------------------------------------------------
// dropblock_mask_apply
// DropBlock mask build over a bit memory and scaled data output.
// ----------------------------------------------------------------------------
`include "dropblock_mask_apply_assert.svh"

module dropblock_mask_apply
	import dbm_pkg::*;
#(
	parameter int MAX_PLANE_WIDTH = 64,
	parameter int MAX_PLANES      = 16,
	parameter int DATA_WIDTH      = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	dbm_in_if.sink               req,
	dbm_out_if.source            rsp,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [CFG_WIDTH-1:0] cfg_data
);

	localparam int DEPTH = MAX_PLANES * MAX_PLANE_WIDTH * MAX_PLANE_WIDTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = AW + 1;
	localparam int WW    = $clog2(MAX_PLANE_WIDTH + 1);
	localparam int PLW   = $clog2(MAX_PLANES + 1);
	localparam int NUMW  = DATA_WIDTH + PW;
	localparam int CW    = $clog2(NUMW);
	localparam logic [NUMW-1:0] QMAX = NUMW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
	localparam logic [NUMW-1:0] QNEG = QMAX + NUMW'(1);

	state_t state, state_nx;

	logic [6:0]  pw_q, bw_q;
	logic [4:0]  pc_q;
	logic [15:0] thr_q;
	logic        train_q;
	logic [1:0]  settle_q;

	logic [WW-1:0]  w_eff, t_eff;
	logic [6:0]     b_eff;
	logic [PLW-1:0] planes;
	logic           noorig;
	logic [PW-1:0]  wsq_q, pp_q, total_q, origins_q;
	logic           noorig_q;

	logic [PW-1:0] spos_q, dpos_q, kept_q, pos_d;
	logic [AW-1:0] pos_q, sw_q;

	logic                  mem_q [DEPTH];
	logic                  rd_q, we, wd;
	logic [AW-1:0]         wa, ra, addr_s1, rowbase_q;
	logic                  cell_v_s1;
	logic [6:0]            i_q, j_q;
	logic [PLW-1:0]        plane_q;
	logic [WW-1:0]         row_q, col_q;

	logic [NUMW-1:0] dnum_q, qn, prod_q;
	logic [PW:0]     drem_q, rem_sh, rem_n;
	logic [PW-1:0]   dden_q;
	logic [CW-1:0]   dcnt_q;
	logic            ge, div_last;

	logic [DATA_WIDTH-1:0] raw_q, mag, res_q;
	logic                  neg, kept_bit_q, err_q;
	logic                  ov_q;
	logic [DATA_WIDTH-1:0] ov_val_q;
	logic                  ov_kept_q, ov_err_q;

	logic acc, last_j, last_i, out_free;

	// Effective geometry from the configuration registers.
	always_comb begin
		if (pw_q == 7'd0) w_eff = WW'(1);
		else if (32'(pw_q) > MAX_PLANE_WIDTH) w_eff = WW'(MAX_PLANE_WIDTH);
		else w_eff = WW'(pw_q);
		b_eff = (bw_q == 7'd0) ? 7'd1 : bw_q;
		if (pc_q == 5'd0) planes = PLW'(1);
		else if (32'(pc_q) > MAX_PLANES) planes = PLW'(MAX_PLANES);
		else planes = PLW'(pc_q);
		noorig = 32'(b_eff) > 32'(w_eff);
		t_eff  = WW'(32'(w_eff) - 32'(b_eff) + 1);
	end

	assign acc      = req.valid && req.ready;
	assign req.ready = (state == S_IDLE) && (settle_q == 2'd0);
	assign out_free = !ov_q || rsp.ready;
	assign last_j   = (j_q == b_eff - 7'd1);
	assign last_i   = (i_q == b_eff - 7'd1);

	// Serial restoring divider, one quotient bit a cycle.
	assign rem_sh   = {drem_q[PW-1:0], dnum_q[NUMW-1]};
	assign ge       = rem_sh >= {1'b0, dden_q};
	assign rem_n    = ge ? rem_sh - {1'b0, dden_q} : rem_sh;
	assign qn       = {dnum_q[NUMW-2:0], ge};
	assign div_last = (dcnt_q == CW'(NUMW - 1));

	assign pos_d = (dpos_q >= total_q) ? '0 : dpos_q;
	assign neg   = raw_q[DATA_WIDTH-1];
	assign mag   = neg ? (~raw_q + DATA_WIDTH'(1)) : raw_q;

	// Mask memory ports: a set bit means the position is dropped.
	always_comb begin
		we = (state == S_SWEEP) || (cell_v_s1 && !rd_q);
		wa = (state == S_SWEEP) ? sw_q : addr_s1;
		wd = (state != S_SWEEP);
		ra = (state == S_SCELL) ? rowbase_q + AW'(j_q) : pos_q;
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[wa] <= wd;
		rd_q <= mem_q[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state <= S_SWEEP;
		else state <= state_nx;
	end

	always_comb begin
		state_nx = state;
		unique case (state)
			S_SWEEP:  if (sw_q == AW'(DEPTH - 1)) state_nx = S_IDLE;
			S_IDLE: begin
				if (acc) begin
					case (kind_t'(req.kind))
						KIND_START: state_nx = S_SWEEP;
						KIND_SEED: begin
							if (!noorig_q && spos_q < origins_q &&
								req.random_fraction <= thr_q)
								state_nx = S_SDIV1;
						end
						KIND_DATA: state_nx = train_q ? S_DREAD : S_WOUT;
						default: state_nx = S_IDLE;
					endcase
				end
			end
			S_SDIV1:  if (div_last) state_nx = S_SDIV2;
			S_SDIV2:  if (div_last) state_nx = S_SBASE;
			S_SBASE:  state_nx = S_SCELL;
			S_SCELL:  if (last_i && last_j) state_nx = S_SDRAIN;
			S_SDRAIN: state_nx = S_IDLE;
			S_DREAD:  state_nx = S_DCHK;
			S_DCHK:   state_nx = (kept_q == '0 || rd_q) ? S_WOUT : S_DMUL;
			S_DMUL:   state_nx = S_DDIV;
			S_DDIV:   if (div_last) state_nx = S_DSAT;
			S_DSAT:   state_nx = S_WOUT;
			S_WOUT:   if (out_free) state_nx = S_IDLE;
			default:  state_nx = S_IDLE;
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pw_q      <= 7'd16;
			bw_q      <= 7'd3;
			pc_q      <= 5'd1;
			thr_q     <= '0;
			train_q   <= 1'b1;
			settle_q  <= 2'd3;
			wsq_q     <= '0;
			pp_q      <= '0;
			noorig_q  <= 1'b1;
			total_q   <= '0;
			origins_q <= '0;
			spos_q    <= '0;
			dpos_q    <= '0;
			kept_q    <= '0;
			sw_q      <= '0;
			cell_v_s1 <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			dcnt_q    <= '0;
			ov_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				settle_q <= 2'd3;
				unique case (reg_idx_t'(cfg_index))
					REG_PLANE_WIDTH: pw_q    <= cfg_data[6:0];
					REG_BLOCK_WIDTH: bw_q    <= cfg_data[6:0];
					REG_PLANE_COUNT: pc_q    <= cfg_data[4:0];
					REG_THRESHOLD:   thr_q   <= cfg_data[15:0];
					REG_TRAIN_MODE:  train_q <= cfg_data[0];
					default: ;
				endcase
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
			wsq_q     <= PW'(32'(w_eff) * 32'(w_eff));
			pp_q      <= PW'(32'(t_eff) * 32'(t_eff));
			noorig_q  <= noorig;
			total_q   <= PW'(32'(planes) * 32'(wsq_q));
			origins_q <= PW'(32'(planes) * 32'(pp_q));

			if (state == S_SWEEP) sw_q <= sw_q + AW'(1);
			else sw_q <= '0;

			cell_v_s1 <= (state == S_SCELL);
			if (cell_v_s1 && !rd_q && kept_q != '0) kept_q <= kept_q - PW'(1);

			if (state == S_IDLE && acc) begin
				case (kind_t'(req.kind))
					KIND_START: begin
						spos_q <= '0;
						dpos_q <= '0;
						kept_q <= total_q;
					end
					KIND_SEED: begin
						if (!noorig_q && spos_q < origins_q) spos_q <= spos_q + PW'(1);
					end
					KIND_DATA: dpos_q <= (pos_d + PW'(1) >= total_q) ? '0 : pos_d + PW'(1);
					default: ;
				endcase
			end

			if (state == S_SBASE) begin
				i_q <= '0;
				j_q <= '0;
			end else if (state == S_SCELL) begin
				if (last_j) begin
					j_q <= '0;
					i_q <= i_q + 7'd1;
				end else begin
					j_q <= j_q + 7'd1;
				end
			end

			if (state == S_SDIV1 || state == S_SDIV2 || state == S_DDIV)
				dcnt_q <= div_last ? '0 : dcnt_q + CW'(1);
			else
				dcnt_q <= '0;

			if (state == S_WOUT && out_free) ov_q <= 1'b1;
			else if (rsp.ready) ov_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state == S_IDLE && acc) begin
			pos_q      <= AW'(pos_d);
			raw_q      <= req.data_value;
			res_q      <= req.data_value;
			kept_bit_q <= 1'b1;
			err_q      <= 1'b0;
			dnum_q     <= NUMW'(spos_q);
			drem_q     <= '0;
			dden_q     <= pp_q;
		end
		case (state)
			S_SDIV1: begin
				dnum_q <= qn;
				drem_q <= rem_n;
				if (div_last) begin
					plane_q <= PLW'(qn);
					dnum_q  <= NUMW'(rem_n);
					drem_q  <= '0;
					dden_q  <= PW'(t_eff);
				end
			end
			S_SDIV2: begin
				dnum_q <= qn;
				drem_q <= rem_n;
				if (div_last) begin
					row_q <= WW'(qn);
					col_q <= WW'(rem_n);
				end
			end
			S_SBASE: rowbase_q <= AW'(32'(plane_q) * 32'(wsq_q) + 32'(row_q) * 32'(w_eff)
				+ 32'(col_q));
			S_SCELL: begin
				if (last_j) rowbase_q <= rowbase_q + AW'(w_eff);
			end
			S_DCHK: begin
				kept_bit_q <= !rd_q;
				err_q      <= (kept_q == '0);
				res_q      <= '0;
				prod_q     <= NUMW'(mag) * NUMW'(total_q);
			end
			S_DMUL: begin
				dnum_q <= prod_q + NUMW'(kept_q >> 1);
				drem_q <= '0;
				dden_q <= kept_q;
			end
			S_DDIV: begin
				dnum_q <= qn;
				drem_q <= rem_n;
			end
			S_DSAT: begin
				if (neg)
					res_q <= (dnum_q > QNEG) ? QNEG[DATA_WIDTH-1:0]
						: ~dnum_q[DATA_WIDTH-1:0] + DATA_WIDTH'(1);
				else
					res_q <= (dnum_q > QMAX) ? QMAX[DATA_WIDTH-1:0] : dnum_q[DATA_WIDTH-1:0];
			end
			default: ;
		endcase
		addr_s1 <= ra;
		if (state == S_WOUT && out_free) begin
			ov_val_q  <= res_q;
			ov_kept_q <= kept_bit_q;
			ov_err_q  <= err_q;
		end
	end

	assign rsp.valid         = ov_q;
	assign rsp.scaled_value  = ov_val_q;
	assign rsp.mask_kept     = ov_kept_q;
	assign rsp.no_kept_error = ov_err_q;

	`DBM_ASSERT_SAME(a_ready_idle, req.ready, state == S_IDLE, "ready outside idle")
	`DBM_ASSERT_NEXT(a_cell_stage, state == S_SCELL, cell_v_s1, "cell stage lost")
	`DBM_ASSERT_SAME(a_err_zero, rsp.valid && rsp.no_kept_error,
		rsp.scaled_value == '0, "error beat carries nonzero data")
	`DBM_ASSERT_NEXT(a_div_end, state == S_DDIV && div_last, state == S_DSAT,
		"divider end missed")

endmodule

FILE: tb/dropblock_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dropblock_checker
// Watches the item, result and register channels of the mask block, keeps its
// own copy of the mask and counters, and compares every result beat in order.
// ----------------------------------------------------------------------------
module dropblock_checker
	import dbm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	dbm_in_if                    req,
	dbm_out_if                   rsp,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [CFG_WIDTH-1:0] cfg_data,
	output int                   mismatches,
	output int                   outstanding
);

	typedef struct packed {
		logic signed [15:0] scaled_value;
		logic               mask_kept;
		logic               no_kept_error;
	} scaled_beat_t;

	scaled_beat_t expected_beats[$];

	logic [6:0]  plane_width;
	logic [6:0]  block_width;
	logic [4:0]  plane_count;
	logic [15:0] drop_threshold;
	logic        train_mode;

	bit          mask_bits[65536];
	int unsigned seed_pos;
	int unsigned data_pos;
	int unsigned kept_count;

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	function automatic int unsigned eff_width();
		if (plane_width < 1) return 1;
		if (plane_width > 64) return 64;
		return plane_width;
	endfunction

	function automatic int unsigned eff_planes();
		if (plane_count < 1) return 1;
		if (plane_count > 16) return 16;
		return plane_count;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Places one seed: clears a square of the mask when the fraction drops it.
	task automatic place_seed(logic [15:0] frac);
		int unsigned w, b, t, per_plane, plane, rem, row, col, p;
		w = eff_width();
		b = (block_width < 1) ? 1 : block_width;
		if (b > w) return;
		t = w - b + 1;
		per_plane = t * t;
		if (seed_pos >= eff_planes() * per_plane) return;
		plane = seed_pos / per_plane;
		rem = seed_pos % per_plane;
		row = rem / t;
		col = rem % t;
		seed_pos++;
		if (frac > drop_threshold) return;
		for (int i = 0; i < b; i++) begin
			for (int j = 0; j < b; j++) begin
				p = plane * w * w + (row + i) * w + (col + j);
				if (p < 65536 && mask_bits[p]) begin
					mask_bits[p] = 0;
					if (kept_count > 0) kept_count--;
				end
			end
		end
	endtask

	function automatic scaled_beat_t predict_scaled(logic [15:0] raw);
		scaled_beat_t r;
		int unsigned total, pos;
		bit neg;
		longint unsigned mag, q;
		total = eff_planes() * eff_width() * eff_width();
		if (data_pos >= total) data_pos = 0;
		pos = data_pos;
		data_pos = (pos + 1 >= total) ? 0 : pos + 1;
		r = '0;
		if (!train_mode) begin
			r.scaled_value = raw;
			r.mask_kept = 1'b1;
			return r;
		end
		r.mask_kept = mask_bits[pos];
		if (kept_count == 0) begin
			r.no_kept_error = 1'b1;
			return r;
		end
		if (!r.mask_kept) return r;
		neg = raw[15];
		mag = neg ? longint'((17'h10000 - raw) & 17'hFFFF) : longint'(raw);
		if (neg && mag == 0) mag = 32768;
		q = (mag * total + kept_count / 2) / kept_count;
		if (neg) r.scaled_value = (q > 32768) ? -16'sd32768 : 16'(-longint'(q));
		else r.scaled_value = (q > 32767) ? 16'sd32767 : 16'(q);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		scaled_beat_t want;
		if (!arst_n) begin
			plane_width    <= 7'd16;
			block_width    <= 7'd3;
			plane_count    <= 5'd1;
			drop_threshold <= 16'd0;
			train_mode     <= 1'b1;
			for (int i = 0; i < 65536; i++) mask_bits[i] = 1;
			seed_pos   = 0;
			data_pos   = 0;
			kept_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PLANE_WIDTH: plane_width    <= cfg_data[6:0];
					REG_BLOCK_WIDTH: block_width    <= cfg_data[6:0];
					REG_PLANE_COUNT: plane_count    <= cfg_data[4:0];
					REG_THRESHOLD:   drop_threshold <= cfg_data[15:0];
					REG_TRAIN_MODE:  train_mode     <= cfg_data[0];
					default: ;
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected result beat", rsp.scaled_value, 0);
				end else begin
					want = expected_beats.pop_front();
					if (rsp.scaled_value !== want.scaled_value)
						report_mismatch("scaled_value", rsp.scaled_value, want.scaled_value);
					if (rsp.mask_kept !== want.mask_kept)
						report_mismatch("mask_kept", rsp.mask_kept, want.mask_kept);
					if (rsp.no_kept_error !== want.no_kept_error)
						report_mismatch("no_kept_error", rsp.no_kept_error,
							want.no_kept_error);
				end
			end
			if (req.valid && req.ready) begin
				case (kind_t'(req.kind))
					KIND_START: begin
						for (int i = 0; i < 65536; i++) mask_bits[i] = 1;
						seed_pos   = 0;
						data_pos   = 0;
						kept_count = eff_planes() * eff_width() * eff_width();
					end
					KIND_SEED: place_seed(req.random_fraction);
					KIND_DATA: expected_beats.push_back(predict_scaled(req.data_value));
					default: ;
				endcase
			end
			outstanding <= expected_beats.size();
		end
	end

	final begin
		if (expected_beats.size() != 0)
			$display("%0d result beats never arrived", expected_beats.size());
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the mask block through several geometries, thresholds and training
// settings with bursty items and a stalling receiver; the checker judges.
// ----------------------------------------------------------------------------
module testbench;
	import dbm_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [2:0]           cfg_index;
	logic [CFG_WIDTH-1:0] cfg_data;
	int                   mismatches;
	int                   outstanding;
	int                   burst_left;
	int                   items_sent;
	int                   data_sent;
	int                   settings_run;
	bit                   hold_request;
	bit                   done_leftover;

	dbm_in_if  #(.DATA_WIDTH(16)) req_if ();
	dbm_out_if #(.DATA_WIDTH(16)) rsp_if ();

	dropblock_mask_apply i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_if),
		.rsp      (rsp_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	dropblock_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_if),
		.rsp        (rsp_if),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	initial begin
		#36_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Receiver: windows of full rate, random stalls or a fixed pattern, plus
	// one long hold-off on request.
	initial begin
		int mode, phase_cnt;
		rsp_if.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			for (int i = 0; i < 200; i++) begin
				@(negedge clk);
				if (hold_request) begin
					rsp_if.ready = 1'b0;
					for (int h = 0; h < 600; h++) @(negedge clk);
					hold_request = 1'b0;
				end
				phase_cnt++;
				case (mode)
					0: rsp_if.ready = 1'b1;
					1: rsp_if.ready = 1'($urandom_range(0, 1));
					default: rsp_if.ready = (phase_cnt % 4) != 3;
				endcase
			end
		end
	end

	task automatic send_item(kind_t kind, logic [15:0] frac, logic [15:0] value);
		req_if.valid           = 1'b1;
		req_if.kind            = kind;
		req_if.random_fraction = frac;
		req_if.data_value      = value;
		forever begin
			#1;
			if (req_if.ready) begin
				@(posedge clk);
				break;
			end
			@(negedge clk);
		end
		@(negedge clk);
		items_sent++;
		if (kind == KIND_DATA) data_sent++;
		if (--burst_left <= 0) begin
			req_if.valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(1, 30);
		end
	endtask

	// Lets every expected beat arrive, then covers a dropped seed that gives
	// no result but may still be clearing the mask.
	task automatic wait_idle();
		req_if.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4400) @(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_WIDTH-1:0] value);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// One tensor: start, one seed per origin plus a couple of spares, then
	// data beats with a little noise mixed in.
	task automatic run_tensor(int pw, int bw, int pc, int thr, bit train, int n_data,
			bit with_hold);
		int w, b, t, origins, lo, hi;
		w = (pw < 1) ? 1 : (pw > 64 ? 64 : pw);
		b = (bw < 1) ? 1 : bw;
		t = (b > w) ? 0 : w - b + 1;
		origins = t * t * ((pc < 1) ? 1 : (pc > 16 ? 16 : pc));
		wait_idle();
		write_reg(REG_PLANE_WIDTH, CFG_WIDTH'(pw));
		write_reg(REG_BLOCK_WIDTH, CFG_WIDTH'(bw));
		write_reg(REG_PLANE_COUNT, CFG_WIDTH'(pc));
		write_reg(REG_THRESHOLD, CFG_WIDTH'(thr));
		write_reg(REG_TRAIN_MODE, CFG_WIDTH'(train));
		settings_run++;
		send_item(KIND_START, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		lo = (thr > 64) ? thr - 64 : 0;
		hi = (thr < 65471) ? thr + 64 : 65535;
		for (int i = 0; i < origins + 2; i++)
			send_item(KIND_SEED, $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
				: 16'($urandom_range(lo, hi)), 16'($urandom_range(0, 65535)));
		for (int i = 0; i < n_data; i++) begin
			if (with_hold && i == n_data / 2) hold_request = 1'b1;
			case ($urandom_range(0, 39))
				0: send_item(KIND_NONE, 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)));
				1: send_item(KIND_SEED, 16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)));
				default: ;
			endcase
			send_item(KIND_DATA, 16'($urandom_range(0, 65535)), pick_value());
		end
	endtask

	initial begin
		logic [15:0] edge_values[6];
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		req_if.valid   = 1'b0;
		req_if.kind    = KIND_START;
		req_if.random_fraction = '0;
		req_if.data_value      = '0;
		hold_request   = 1'b0;
		burst_left     = 5;
		items_sent     = 0;
		data_sent      = 0;
		settings_run   = 0;
		edge_values    = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h0100};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Before any start nothing counts as kept, so every beat is an error.
		send_item(KIND_DATA, 16'h0000, 16'h7FFF);
		send_item(KIND_DATA, 16'hFFFF, 16'h8000);
		send_item(KIND_NONE, 16'hFFFF, 16'hFFFF);
		send_item(KIND_DATA, 16'h1234, 16'h0001);

		// Directed tensor: two 4x4 planes, 2x2 blocks, threshold at one half.
		wait_idle();
		write_reg(REG_PLANE_WIDTH, 16'd4);
		write_reg(REG_BLOCK_WIDTH, 16'd2);
		write_reg(REG_PLANE_COUNT, 16'd2);
		write_reg(REG_THRESHOLD, 16'h8000);
		write_reg(REG_TRAIN_MODE, 16'd1);
		settings_run++;
		send_item(KIND_START, 16'h0000, 16'h0000);
		send_item(KIND_SEED, 16'h0000, 16'h0000);
		send_item(KIND_SEED, 16'hFFFF, 16'h0000);
		send_item(KIND_SEED, 16'h8000, 16'h0000);
		send_item(KIND_SEED, 16'h8001, 16'h0000);
		for (int i = 0; i < 16; i++) send_item(KIND_SEED, 16'hC000, 16'h0000);
		for (int i = 0; i < 12; i++) send_item(KIND_DATA, 16'h0000, edge_values[i % 6]);

		run_tensor(1, 1, 1, 65535, 1'b1, 80, 1'b0);
		run_tensor(127, 127, 31, $urandom_range(0, 65535), 1'b1, 110, 1'b0);
		run_tensor(8, 9, 3, $urandom_range(0, 65535), 1'b1, 100, 1'b0);
		run_tensor(6, 3, 4, $urandom_range(8000, 40000), 1'b1, 120, 1'b1);
		run_tensor(5, 0, 2, $urandom_range(0, 20000), 1'b1, 100, 1'b0);
		run_tensor(7, 2, 1, $urandom_range(0, 65535), 1'b0, 90, 1'b0);
		run_tensor(16, 3, 1, 0, 1'b1, 100, 1'b0);
		run_tensor(10, 4, 3, $urandom_range(0, 30000), 1'b1, 110, 1'b0);

		req_if.valid = 1'b0;
		wait_idle();
		repeat (100) @(negedge clk);
		$display("Run covered %0d items, %0d of them data, over %0d register settings,",
			items_sent, data_sent, settings_run);
		$display("including clamped and oversized blocks, full drop and training off.");
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
